// ----- rtl/wmm_pkg.sv -----
// Shared types and constants for the windowed min/max/mean monitor.
// No dependencies; imported by the top level.
`default_nettype none

package wmm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_NUM_SIGNALS  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd1;
  localparam logic [1:0] CFG_PRINT_CYCLES = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register field widths
  localparam int NSIG_W   = 4;
  localparam int WSIZE_W  = 9;
  localparam int PERIOD_W = 16;

  // Stream payload widths
  localparam int SAMPLE_W   = 32;
  localparam int CHAN_W     = 3;
  localparam int TOTAL_W    = 40;
  localparam int AVG_W      = 48;
  localparam int FRAC_W     = 16;
  localparam int OUT_DATA_W = 160;

  // Reset values of the configuration registers
  localparam logic [NSIG_W-1:0]   NSIG_RST   = 4'd1;
  localparam logic [WSIZE_W-1:0]  WSIZE_RST  = 9'd256;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1;

endpackage : wmm_pkg

`default_nettype wire

// ----- rtl/wmm_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module wmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : wmm_ram

`default_nettype wire

// ----- rtl/windowed_min_max_mean_monitor.sv -----
// Flow: a sample is written to the store in the cycle it is accepted; a frame that
//   completes a report stalls input while, per channel, the store window is swept,
//   a restoring division runs and the result is loaded into the output register,
//   which is delayed under back-pressure.
// Throughput: one sample per cycle between reports; sweeps are bound by the one read port.
// Reset (rst_n, synchronous, active low): control and config registers return to
//   defaults; a clearing pass zeroes all 2**(CH_W+RW) entries before input is taken.
`default_nettype none

module windowed_min_max_mean_monitor
  import wmm_pkg::*;
#(
  parameter int MAX_SIGNALS  = 8,
  parameter int WINDOW_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [SAMPLE_W-1:0]   in_tdata,   // [31:0] sample
  // statistics result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] channel, [34:3] peak_high, [66:35] peak_low, [106:67] window_total,
  // [154:107] average_q16, [159:155] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,  // final_flag
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int CH_W   = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;   // channel index
  localparam int CNT_W  = CH_W + 1;                                      // channel count
  localparam int RW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1; // ring index
  localparam int WIN_W  = RW + 1;                                        // window count
  localparam int MEM_AW = CH_W + RW;
  localparam int MEM_DEPTH = 2 ** MEM_AW;
  localparam int SUM_W  = (SAMPLE_W + 1 + RW > TOTAL_W) ? SAMPLE_W + 1 + RW : TOTAL_W;
  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int DC_W   = $clog2(DIV_W + 1);
  localparam int CMP_W  = 16;   // wide enough for WINDOW_DEPTH and the window register

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DIV,
    ST_EMIT
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers: always writable
  // ---------------------------------------------------------------------------
  logic [NSIG_W-1:0]   num_sig_r;
  logic [WSIZE_W-1:0]  win_size_r;
  logic [PERIOD_W-1:0] period_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sig_r  <= NSIG_RST;
      win_size_r <= WSIZE_RST;
      period_r   <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_SIGNALS:  num_sig_r  <= cfg_data[NSIG_W-1:0];
        CFG_WINDOW_SIZE:  win_size_r <= cfg_data[WSIZE_W-1:0];
        CFG_PRINT_CYCLES: period_r   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective values: zero acts as one, oversize values clamp to the build limits
  logic [CNT_W-1:0]    nsig_eff;
  logic [WIN_W-1:0]    win_eff;
  logic [PERIOD_W-1:0] per_eff;

  always_comb begin
    if (num_sig_r == '0) begin
      nsig_eff = CNT_W'(1);
    end else if ({1'b0, num_sig_r} > 5'(MAX_SIGNALS)) begin
      nsig_eff = CNT_W'(MAX_SIGNALS);
    end else begin
      nsig_eff = CNT_W'(num_sig_r);
    end

    if (win_size_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (CMP_W'(win_size_r) > CMP_W'(WINDOW_DEPTH)) begin
      win_eff = WIN_W'(WINDOW_DEPTH);
    end else begin
      win_eff = WIN_W'(win_size_r);
    end

    per_eff = (period_r == '0) ? PERIOD_W'(1) : period_r;
  end

  // ---------------------------------------------------------------------------
  // Window store: entry address is {channel, ring position}
  // ---------------------------------------------------------------------------
  logic                wr_en;
  logic [MEM_AW-1:0]   wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic [MEM_AW-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;

  wmm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  state_t              state_r;
  logic [MEM_AW-1:0]   clr_r;       // clearing pass address
  logic [RW-1:0]       ring_r;      // shared ring position
  logic [CH_W-1:0]     cp_r;        // next channel in the frame
  logic [PERIOD_W-1:0] fc_r;        // frames since last report
  logic [CH_W-1:0]     ch_r;        // channel being reported
  logic [WIN_W-1:0]    rd_idx_r;    // sweep read index
  logic                rd_vld_r;    // read data valid this cycle
  logic                first_r;     // next read data is the first of the window
  logic [SAMPLE_W-1:0] hi_r;
  logic [SAMPLE_W-1:0] lo_r;
  logic [SUM_W-1:0]    sum_r;
  logic                neg_r;
  logic [DIV_W-1:0]    q_r;         // dividend shifting out, quotient shifting in
  logic [WIN_W-1:0]    rem_r;
  logic [DC_W-1:0]     div_cnt_r;
  logic                out_tvalid_r;
  logic                out_tlast_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                in_acc;
  logic [CNT_W-1:0]    cp_inc;
  logic [WIN_W-1:0]    ring_inc;
  logic                frame_end;
  logic [RW-1:0]       ring_nxt;
  logic [PERIOD_W-1:0] fc_nxt;
  logic                report_due;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cp_inc     = {1'b0, cp_r} + CNT_W'(1);
    ring_inc   = {1'b0, ring_r} + WIN_W'(1);
    frame_end  = (cp_inc >= nsig_eff);
    ring_nxt   = (ring_inc >= win_eff) ? '0 : ring_inc[RW-1:0];
    fc_nxt     = fc_r + PERIOD_W'(1);
    report_due = frame_end && (fc_nxt >= per_eff);
  end

  // Store port selection: clearing pass or sample write; reads belong to the sweep
  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      wr_en   = in_acc;
      wr_addr = {cp_r, ring_r};
      wr_data = in_tdata;
    end
    rd_addr = {ch_r, rd_idx_r[RW-1:0]};
  end

  // Sweep accumulation, next values
  logic [SUM_W-1:0] rd_ext;
  logic [SUM_W-1:0] sum_mag;

  assign rd_ext  = {{(SUM_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
  assign sum_mag = sum_r[SUM_W-1] ? (~sum_r + SUM_W'(1)) : sum_r;

  // One restoring division step
  logic [WIN_W:0] rem_sh;
  logic [WIN_W:0] rem_sub;
  logic           q_bit;

  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, win_eff};
    q_bit   = (rem_sh >= {1'b0, win_eff});
  end

  // Result assembly
  logic [DIV_W-1:0] avg_full;
  logic             last_ch;
  logic             emit_go;

  assign avg_full = neg_r ? (~q_r + DIV_W'(1)) : q_r;
  assign last_ch  = (({1'b0, ch_r} + CNT_W'(1)) == nsig_eff);
  assign emit_go  = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      ring_r       <= '0;
      cp_r         <= '0;
      fc_r         <= '0;
      ch_r         <= '0;
      rd_idx_r     <= '0;
      rd_vld_r     <= 1'b0;
      first_r      <= 1'b1;
      div_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // output register: loaded by the emit step, else drained by the receiver
      if (emit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + MEM_AW'(1);
          if (clr_r == {MEM_AW{1'b1}}) begin
            state_r <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_acc) begin
            if (frame_end) begin
              cp_r   <= '0;
              ring_r <= ring_nxt;
              if (report_due) begin
                fc_r     <= '0;
                ch_r     <= '0;
                rd_idx_r <= '0;
                rd_vld_r <= 1'b0;
                first_r  <= 1'b1;
                state_r  <= ST_SWEEP;
              end else begin
                fc_r <= fc_nxt;
              end
            end else begin
              cp_r <= cp_inc[CH_W-1:0];
            end
          end
        end

        ST_SWEEP: begin
          // issue reads at one per cycle; read data is registered and comes back in the following cycle
          if (rd_idx_r < win_eff) begin
            rd_idx_r <= rd_idx_r + WIN_W'(1);
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end

          if (rd_vld_r) begin
            first_r <= 1'b0;
            if (first_r) begin
              hi_r  <= rd_data;
              lo_r  <= rd_data;
              sum_r <= rd_ext;
            end else begin
              if ($signed(rd_data) > $signed(hi_r)) hi_r <= rd_data;
              if ($signed(rd_data) < $signed(lo_r)) lo_r <= rd_data;
              sum_r <= sum_r + rd_ext;
            end
          end

          if ((rd_idx_r == win_eff) && !rd_vld_r) begin
            neg_r     <= sum_r[SUM_W-1];
            q_r       <= {sum_mag, {FRAC_W{1'b0}}};
            rem_r     <= '0;
            div_cnt_r <= DC_W'(DIV_W);
            state_r   <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_cnt_r != '0) begin
            rem_r     <= q_bit ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
            q_r       <= {q_r[DIV_W-2:0], q_bit};
            div_cnt_r <= div_cnt_r - DC_W'(1);
          end else begin
            state_r <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (emit_go) begin
            out_tlast_r  <= last_ch;
            out_tdata_r  <= {5'd0, avg_full[AVG_W-1:0], sum_r[TOTAL_W-1:0],
                             lo_r, hi_r, CHAN_W'(ch_r)};
            if (last_ch) begin
              state_r <= ST_IDLE;
            end else begin
              ch_r     <= ch_r + CH_W'(1);
              rd_idx_r <= '0;
              rd_vld_r <= 1'b0;
              first_r  <= 1'b1;
              state_r  <= ST_SWEEP;
            end
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_tlast_r;
  assign out_tdata  = out_tdata_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_tvalid_r)
    else $error("result presented during clearing pass");

  a_ring_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ring_r} < WIN_W'(WINDOW_DEPTH))
    else $error("ring position beyond window depth");

  a_chan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cp_r} < CNT_W'(MAX_SIGNALS))
    else $error("channel position beyond channel limit");

  a_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SWEEP))
    else $error("store read data outside a sweep");

endmodule : windowed_min_max_mean_monitor

`default_nettype wire
